FILE: rtl/csv_field_splitter_core_defines.svh
// assertion macros used by the csv field splitter rtl
// depends on clk and arst_n being visible in the module that uses them
`ifndef CSV_FIELD_SPLITTER_CORE_DEFINES_SVH
`define CSV_FIELD_SPLITTER_CORE_DEFINES_SVH

// implication checked on every clock edge outside reset
`define CSV_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define CSV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/csv_fs_pkg.sv
// types and constants of the csv field splitter
// no dependencies
`default_nettype none

package csv_fs_pkg;

	// parser mode
	typedef enum logic [1:0] {
		MODE_START      = 2'd0,
		MODE_PLAIN      = 2'd1,
		MODE_QUOTED     = 2'd2,
		MODE_QUOTE_SEEN = 2'd3
	} mode_t;

	// result kind codes
	typedef enum logic [2:0] {
		KIND_DATA     = 3'd0,
		KIND_CELL_END = 3'd1,
		KIND_ROW_END  = 3'd2,
		KIND_EOF_ROW  = 3'd3,
		KIND_EOF_NONE = 3'd4
	} kind_t;

	// special characters
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_QUOTE   = 8'h22;

	// input transaction
	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_input;
	} item_t;

	// result transaction
	typedef struct packed {
		kind_t      kind;
		logic [7:0] value_byte;
		logic [7:0] cell_index;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/csv_fs_parser.sv
// parse state machine of the csv field splitter: mode, empty flag, cell position
// depends on csv_fs_pkg and csv_field_splitter_core_defines.svh
`default_nettype none
`include "csv_field_splitter_core_defines.svh"

module csv_fs_parser #(
	parameter int MAX_CELL_INDEX = 255
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire csv_fs_pkg::item_t item,
	output logic                   res_valid,
	output csv_fs_pkg::result_t    res
);
	import csv_fs_pkg::*;

	localparam int PosW = $clog2(MAX_CELL_INDEX + 1);
	localparam logic [PosW-1:0] PosMax = PosW'(MAX_CELL_INDEX);

	mode_t           mode_q, mode_d;
	logic            empty_q, empty_d;
	logic [PosW-1:0] pos_q, pos_d;
	logic [PosW+7:0] pos_ext;
	logic [7:0]      b;
	logic [PosW-1:0] pos_inc;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_START;
			empty_q <= 1'b1;
			pos_q   <= '0;
		end else if (step) begin
			mode_q  <= mode_d;
			empty_q <= empty_d;
			pos_q   <= pos_d;
		end
	end

	assign b       = item.text_byte;
	assign pos_ext = {8'd0, pos_q};
	assign pos_inc = (pos_q < PosMax) ? pos_q + PosW'(1) : pos_q;

	// next state and result for one byte
	always_comb begin
		mode_d         = mode_q;
		empty_d        = empty_q;
		pos_d          = pos_q;
		res_valid      = 1'b1;
		res.kind       = KIND_DATA;
		res.value_byte = b;
		res.cell_index = pos_ext[7:0];
		if (item.end_of_input) begin
			res.value_byte = 8'd0;
			if (pos_q == '0 && empty_q) begin
				res.kind       = KIND_EOF_NONE;
				res.cell_index = 8'd0;
			end else begin
				res.kind = KIND_EOF_ROW;
			end
			mode_d  = MODE_START;
			empty_d = 1'b1;
			pos_d   = '0;
		end else begin
			unique case (mode_q) inside
				MODE_START, MODE_PLAIN: begin
					if (mode_q == MODE_START && b == CH_QUOTE) begin
						mode_d    = MODE_QUOTED;
						res_valid = 1'b0;
					end else if (b == CH_COMMA) begin
						res.kind = KIND_CELL_END;
						mode_d   = MODE_START;
						empty_d  = 1'b1;
						pos_d    = pos_inc;
					end else if (b == CH_NEWLINE) begin
						res.kind = KIND_ROW_END;
						mode_d   = MODE_START;
						empty_d  = 1'b1;
						pos_d    = '0;
					end else begin
						mode_d  = MODE_PLAIN;
						empty_d = 1'b0;
					end
				end
				MODE_QUOTED: begin
					if (b == CH_QUOTE) begin
						mode_d    = MODE_QUOTE_SEEN;
						res_valid = 1'b0;
					end else begin
						empty_d = 1'b0;
					end
				end
				MODE_QUOTE_SEEN: begin
					// doubled quote is a data quote, anything else closes the cell
					if (b == CH_QUOTE) begin
						mode_d  = MODE_QUOTED;
						empty_d = 1'b0;
					end else if (b == CH_NEWLINE) begin
						res.kind = KIND_ROW_END;
						mode_d   = MODE_START;
						empty_d  = 1'b1;
						pos_d    = '0;
					end else begin
						res.kind = KIND_CELL_END;
						mode_d   = MODE_START;
						empty_d  = 1'b1;
						pos_d    = pos_inc;
					end
				end
				default: begin
					mode_d = MODE_START;
				end
			endcase
		end
	end

	// checks
	`CSV_ASSERT_NEXT(a_eof_resets, step && item.end_of_input,
		pos_q == '0 && empty_q && mode_q == MODE_START, "state not cleared after end of input")
	`CSV_ASSERT_IMPL(a_eof_none_zero, res_valid && res.kind == KIND_EOF_NONE,
		res.cell_index == 8'd0 && res.value_byte == 8'd0, "empty end of input carries data")
	`CSV_ASSERT_NEXT(a_data_not_empty, step && res_valid && res.kind == KIND_DATA,
		!empty_q, "cell still empty after a data byte")
	`CSV_ASSERT_IMPL(a_pos_sat, 1'b1, pos_q <= PosMax, "cell position past its maximum")

endmodule

`default_nettype wire

FILE: rtl/csv_field_splitter_core.sv
// top level of the csv field splitter: input register, parser, result register
// depends on csv_fs_pkg and csv_fs_parser
`default_nettype none

// Splits a byte stream into cells and rows, one input transaction per cycle
// sustained while the result side is not stalled. Each byte is held in an
// input register, goes through the parser, which updates its small mode
// register, and lands in a result register. Opening and closing quotes give
// no result. The input stalls when the result register is full and not taken
// while the input register holds a byte; the input still accepts while the
// input register drains into a free result slot.
module csv_field_splitter_core #(
	parameter int MAX_CELL_INDEX = 255
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire csv_fs_pkg::item_t item,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output csv_fs_pkg::result_t    result
);
	import csv_fs_pkg::*;

	logic    valid_s1, valid_s2;
	item_t   item_s1;
	result_t res_s2;
	logic    adv_s2, step;
	logic    res_valid;
	result_t res;

	assign adv_s2     = !valid_s2 || result_ready;
	assign step       = valid_s1 && adv_s2;
	assign item_ready = !valid_s1 || adv_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	csv_fs_parser #(
		.MAX_CELL_INDEX(MAX_CELL_INDEX)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.item     (item_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			res_s2 <= res;
		end
	end

	assign result_valid = valid_s2;
	assign result       = res_s2;

endmodule

`default_nettype wire
